// File: rtl/window_median_filter_core_defines.svh
// Assertion helpers for the median filter checker.
`ifndef WINDOW_MEDIAN_FILTER_CORE_DEFINES_SVH
`define WINDOW_MEDIAN_FILTER_CORE_DEFINES_SVH

// Same-cycle implication.
`define WMF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("median filter check failed");

// Next-cycle implication.
`define WMF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("median filter check failed");

`endif

// File: rtl/wmf_pkg.sv
package wmf_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_RADIUS_DEF = 3;

  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [15:0] HEIGHT_RST = 16'd480;
  localparam logic [1:0]  RADX_RST   = 2'd1;
  localparam logic [1:0]  RADY_RST   = 2'd1;

  localparam logic [1:0] CFG_IMG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_RADIUS_X   = 2'd2;
  localparam logic [1:0] CFG_RADIUS_Y   = 2'd3;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic valid;
    pix_t pix;
  } cell_t;

endpackage

// File: rtl/wmf_ifs.sv
interface wmf_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  modport source (output valid, req_type, in_red, in_green, in_blue, input ready);
  modport sink (input valid, req_type, in_red, in_green, in_blue, output ready);
endinterface

interface wmf_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_end;
  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

interface wmf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/wmf_ram.sv
module wmf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 7168
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/wmf_sort_cell.sv
module wmf_sort_cell #(
  parameter bit FIRST = 1'b0
) (
  input  logic          clk,
  input  logic          clear,
  input  logic          ins,
  input  wmf_pkg::pix_t x,
  input  wmf_pkg::cell_t prev,
  output wmf_pkg::cell_t self
);
  import wmf_pkg::*;

  cell_t self_next;

  function automatic logic [7:0] pick(logic own_valid, logic [7:0] own, logic [7:0] left,
                                      logic [7:0] xv);
    logic [7:0] res;
    res = own;
    if (!own_valid || xv < own) begin
      res = (FIRST || xv >= left) ? xv : left;
    end
    return res;
  endfunction

  always_comb begin
    self_next = self;
    if (FIRST || prev.valid) begin
      self_next.valid     = 1'b1;
      self_next.pix.red   = pick(self.valid, self.pix.red, prev.pix.red, x.red);
      self_next.pix.green = pick(self.valid, self.pix.green, prev.pix.green, x.green);
      self_next.pix.blue  = pick(self.valid, self.pix.blue, prev.pix.blue, x.blue);
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      self.valid <= 1'b0;
    end else if (ins) begin
      self <= self_next;
    end
  end
endmodule

// File: rtl/wmf_sorter.sv
module wmf_sorter #(
  parameter int CELLS = 49
) (
  input  logic                     clk,
  input  logic                     clear,
  input  logic                     ins,
  input  wmf_pkg::pix_t            x,
  input  logic [$clog2(CELLS)-1:0] sel,
  output wmf_pkg::pix_t            median
);
  import wmf_pkg::*;

  cell_t chain [CELLS];

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    if (i == 0) begin : g_first
      wmf_sort_cell #(.FIRST(1'b1)) u_cell (
        .clk(clk), .clear(clear), .ins(ins), .x(x), .prev(chain[0]), .self(chain[0])
      );
    end else begin : g_rest
      wmf_sort_cell #(.FIRST(1'b0)) u_cell (
        .clk(clk), .clear(clear), .ins(ins), .x(x), .prev(chain[i-1]), .self(chain[i])
      );
    end
  end

  assign median = chain[sel].pix;
endmodule

// File: rtl/window_median_filter_core.sv
// Two-dimensional median filter over an RGB frame in raster order.
// Channels: req takes pixel beats (req_type 0) or drain beats (req_type 1);
// res gives one median pixel with frame_end on the last pixel of a frame;
// cfg writes img_width, img_height, win_radius_x, win_radius_y by index 0..3.
// A cfg write restarts the frame; write only while the block is idle.
// Each accepted beat is handled on its own: the pixel is stored, then the block
// tests whether an output is due; if one is, it steps back through the row ring
// to locate the window, reads one window pixel per cycle from the ring (one
// read port) into the insertion sorting chain, inserts the last read pixel and
// picks the median. The window holds up to 49 pixels inside the image and
// reaches up to ry rows above the output row.
// req.ready is low while a beat is in work and while a result waits;
// a stalled receiver holds res.valid and the payload until taken.
// Reset (rst, synchronous) restores the register defaults and restarts the
// frame; the row ring needs no clearing.
module window_median_filter_core
  import wmf_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input logic clk,
  input logic rst,
  wmf_req_if.sink   req,
  wmf_res_if.source res,
  wmf_cfg_if.sink   cfg
);
  localparam int SPAN  = 2 * MAX_RADIUS + 1;
  localparam int CELLS = SPAN * SPAN;
  localparam int DEPTH = MAX_WIDTH * SPAN;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int SW    = $clog2(SPAN + 1);
  localparam int NW    = $clog2(CELLS + 1);
  localparam int XW    = (WW > 11) ? WW : 11;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_BACK  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_LAST  = 3'd4;
  localparam logic [2:0] S_PICK  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]  state;
  logic [10:0] img_width;
  logic [15:0] img_height;
  logic [1:0]  win_radius_x;
  logic [1:0]  win_radius_y;

  logic [CW-1:0] in_col, out_col;
  logic [15:0]   in_row, out_row;
  logic [AW-1:0] in_addr, out_addr, cur, row_start;
  logic [1:0]    back_cnt, dr;
  logic [2:0]    dc;
  logic [SW-1:0] ncols, nrows, k, j;
  logic [NW-1:0] cnt;
  logic          rd_pend, last;
  logic [7:0]    o_red, o_green, o_blue;
  logic          o_end;

  logic [WW-1:0] w;
  logic [15:0]   h;
  logic [1:0]    rx, ry;
  logic [16:0]   tr_sum;
  logic [15:0]   tr;
  logic [CW:0]   tc_sum;
  logic [WW-1:0] tc;
  logic          due;
  logic          in_acc, cfg_acc, store;
  logic          clear_sort;
  pix_t          rdata, median;

  always_comb begin
    if (img_width == 11'd0) begin
      w = WW'(1);
    end else if (XW'(img_width) > XW'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(img_width);
    end
    h  = (img_height == 16'd0) ? 16'd1 : img_height;
    rx = (int'(win_radius_x) > MAX_RADIUS) ? 2'(MAX_RADIUS) : win_radius_x;
    ry = (int'(win_radius_y) > MAX_RADIUS) ? 2'(MAX_RADIUS) : win_radius_y;
  end

  always_comb begin
    tr_sum = {1'b0, out_row} + 17'(ry);
    tr     = (tr_sum < 17'(h - 16'd1)) ? tr_sum[15:0] : h - 16'd1;
    tc_sum = {1'b0, out_col} + (CW + 1)'(rx);
    tc     = ((CW + 1)'(tc_sum) < (CW + 1)'(w - WW'(1))) ? WW'(tc_sum) : w - WW'(1);
    due    = (out_row < h) &&
             ((tr < in_row) || ((tr == in_row) && (tc < WW'(in_col))));
    dr     = (out_row < 16'(ry)) ? out_row[1:0] : ry;
    dc     = (out_col < CW'(rx)) ? 3'(out_col) : {1'b0, rx};
    last   = (out_row == h - 16'd1) && (WW'(out_col) == w - WW'(1));
  end

  function automatic logic [AW-1:0] inc_wrap(logic [AW-1:0] a);
    return (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] sub_wrap(logic [AW-1:0] a, logic [AW:0] d);
    logic [AW:0] ext;
    ext = {1'b0, a};
    return (ext >= d) ? AW'(ext - d) : AW'(ext + (AW + 1)'(DEPTH) - d);
  endfunction

  function automatic logic [AW-1:0] add_wrap(logic [AW-1:0] a, logic [AW:0] d);
    logic [AW+1:0] s;
    s = {2'b0, a} + {1'b0, d};
    return (s >= (AW + 2)'(DEPTH)) ? AW'(s - (AW + 2)'(DEPTH)) : AW'(s);
  endfunction

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign in_acc    = req.valid && req.ready;
  assign cfg_acc   = cfg.valid && cfg.ready;
  assign store     = in_acc && (req.req_type == REQ_PIXEL) && (in_row < h);
  assign clear_sort = (state == S_CHECK);

  assign res.valid     = (state == S_OUT);
  assign res.out_red   = o_red;
  assign res.out_green = o_green;
  assign res.out_blue  = o_blue;
  assign res.frame_end = o_end;

  wmf_ram #(.WIDTH($bits(pix_t)), .DEPTH(DEPTH)) u_ring (
    .clk(clk), .we(store), .waddr(in_addr),
    .wdata({req.in_red, req.in_green, req.in_blue}),
    .raddr(cur), .rdata(rdata)
  );

  wmf_sorter #(.CELLS(CELLS)) u_sort (
    .clk(clk), .clear(clear_sort), .ins(rd_pend), .x(rdata),
    .sel(($clog2(CELLS))'(cnt >> 1)), .median(median)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      img_width    <= WIDTH_RST;
      img_height   <= HEIGHT_RST;
      win_radius_x <= RADX_RST;
      win_radius_y <= RADY_RST;
      in_col       <= '0;
      in_row       <= '0;
      out_col      <= '0;
      out_row      <= '0;
      in_addr      <= '0;
      out_addr     <= '0;
      rd_pend      <= 1'b0;
    end else begin
      rd_pend <= (state == S_READ);
      if (cfg_acc) begin
        case (cfg.index)
          CFG_IMG_WIDTH:  img_width    <= cfg.data[10:0];
          CFG_IMG_HEIGHT: img_height   <= cfg.data;
          CFG_RADIUS_X:   win_radius_x <= cfg.data[1:0];
          CFG_RADIUS_Y:   win_radius_y <= cfg.data[1:0];
          default:        img_width    <= img_width;
        endcase
        in_col   <= '0;
        in_row   <= '0;
        out_col  <= '0;
        out_row  <= '0;
        in_addr  <= '0;
        out_addr <= '0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (store) begin
              in_addr <= inc_wrap(in_addr);
              if (WW'(in_col) + WW'(1) >= w) begin
                in_col <= '0;
                in_row <= in_row + 16'd1;
              end else begin
                in_col <= in_col + CW'(1);
              end
            end
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (due) begin
            back_cnt <= dr;
            nrows    <= SW'(tr - out_row) + SW'(dr) + SW'(1);
            ncols    <= SW'(tc - WW'(out_col)) + SW'(dc) + SW'(1);
            cur      <= out_addr;
            cnt      <= '0;
            state    <= S_BACK;
          end else begin
            state <= S_IDLE;
          end
        end
        S_BACK: begin
          if (back_cnt != 2'd0) begin
            cur      <= sub_wrap(cur, (AW + 1)'(w));
            back_cnt <= back_cnt - 2'd1;
          end else begin
            cur       <= sub_wrap(cur, (AW + 1)'(dc));
            row_start <= sub_wrap(cur, (AW + 1)'(dc));
            k         <= '0;
            j         <= '0;
            state     <= S_READ;
          end
        end
        S_READ: begin
          if (k != ncols - SW'(1)) begin
            cur <= inc_wrap(cur);
            k   <= k + SW'(1);
          end else if (j != nrows - SW'(1)) begin
            cur       <= add_wrap(row_start, (AW + 1)'(w));
            row_start <= add_wrap(row_start, (AW + 1)'(w));
            k         <= '0;
            j         <= j + SW'(1);
          end else begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          state <= S_PICK;
        end
        S_PICK: begin
          o_red   <= median.red;
          o_green <= median.green;
          o_blue  <= median.blue;
          o_end   <= last;
          if (last) begin
            in_col   <= '0;
            in_row   <= '0;
            out_col  <= '0;
            out_row  <= '0;
            in_addr  <= '0;
            out_addr <= '0;
          end else begin
            out_addr <= inc_wrap(out_addr);
            if (WW'(out_col) + WW'(1) >= w) begin
              out_col <= '0;
              out_row <= out_row + 16'd1;
            end else begin
              out_col <= out_col + CW'(1);
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (res.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
    if (rd_pend) begin
      cnt <= cnt + NW'(1);
    end
  end
endmodule

// File: rtl/wmf_checker.sv
`include "window_median_filter_core_defines.svh"

module wmf_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_valid,
  input logic cfg_ready
);
  `WMF_ASSERT_NEXT(a_one_beat_at_a_time, in_valid && in_ready, !in_ready)
  `WMF_ASSERT_NOW(a_no_take_while_result, out_valid, !in_ready)
  `WMF_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid)
  `WMF_ASSERT_NEXT(a_result_needs_beat, !out_valid && in_ready && !in_valid, !out_valid)
  `WMF_ASSERT_NOW(a_cfg_open, cfg_valid, cfg_ready)
endmodule

bind window_median_filter_core wmf_checker u_wmf_checker (
  .clk(clk), .rst(rst),
  .in_valid(req.valid), .in_ready(req.ready),
  .out_valid(res.valid), .out_ready(res.ready),
  .cfg_valid(cfg.valid), .cfg_ready(cfg.ready)
);
